// ----- design/fsg_pkg.sv -----
package fsg_pkg;

  typedef logic [2:0] cell_t;
  typedef logic [1:0] op_t;

  localparam op_t OP_SPAWN = 2'd0;
  localparam op_t OP_TICK  = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  localparam cell_t CELL_EMPTY = 3'd0;

  typedef struct packed {
    logic  moved;
    cell_t nl;
    cell_t nm;
    cell_t nr;
  } move_t;

  // one grain against the three cells below it
  function automatic move_t settle(input cell_t g, input cell_t l, input cell_t m,
                                   input cell_t r, input logic lv, input logic rv);
    move_t mv;
    mv.moved = 1'b0;
    mv.nl    = l;
    mv.nm    = m;
    mv.nr    = r;
    if (g != CELL_EMPTY) begin
      if (m == CELL_EMPTY) begin
        mv.nm    = g;
        mv.moved = 1'b1;
      end else if (lv && l == CELL_EMPTY) begin
        mv.nl    = g;
        mv.moved = 1'b1;
      end else if (rv && r == CELL_EMPTY) begin
        mv.nr    = g;
        mv.moved = 1'b1;
      end
    end
    return mv;
  endfunction

endpackage

// ----- design/fsg_if.sv -----
interface fsg_in_if;
  import fsg_pkg::*;
  logic  valid;
  logic  ready;
  op_t   operation;
  logic  [7:0] cell_row;
  logic  [7:0] cell_col;
  cell_t grain_color;

  modport source (output valid, output operation, output cell_row, output cell_col,
                  output grain_color, input ready);
  modport sink (input valid, input operation, input cell_row, input cell_col,
                input grain_color, output ready);
endinterface

interface fsg_out_if;
  import fsg_pkg::*;
  logic  valid;
  logic  ready;
  cell_t cell_value;
  logic  placed;

  modport source (output valid, output cell_value, output placed, input ready);
  modport sink (input valid, input cell_value, input placed, output ready);
endinterface

// ----- design/falling_sand_grid_step_top.sv -----
// spawn and read: the result passes the ST_SPAWN or ST_READ state, then the output
// register; out of range, spawn with colour zero or unused operation: registered the next cycle
// tick: one cell a cycle while a row is swept, with ST_LAST, ST_TAIL1 and ST_TAIL2
// at each row end; two row-parity memory banks, each with one read and one write port
// reset: a clearing pass writes all 2**(HRW+CW) words of both banks, no beat taken
module falling_sand_grid_step_top #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  fsg_in_if.sink    in_bus,
  fsg_out_if.source out_bus
);
  import fsg_pkg::*;

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int HRW   = (RW > 1) ? RW - 1 : 1;
  localparam int AW    = HRW + CW;
  localparam int DEPTH = 1 << AW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SPAWN = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;
  localparam logic [2:0] ST_LAST  = 3'd5;
  localparam logic [2:0] ST_TAIL1 = 3'd6;
  localparam logic [2:0] ST_TAIL2 = 3'd7;

  function automatic logic [AW-1:0] baddr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return {HRW'(r >> 1), c};
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] pc_r, pc_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic          rd_first_r, rd_first_nxt;
  logic          w0v_r, w0v_nxt;
  cell_t         w0_r, w0_nxt;
  cell_t         w1_r, w1_nxt;
  cell_t         curd_r, curd_nxt;
  logic [RW-1:0] key_row_r, key_row_nxt;
  logic [CW-1:0] key_col_r, key_col_nxt;
  cell_t         color_r, color_nxt;
  logic          out_valid_r, out_valid_nxt;
  cell_t         out_value_r, out_value_nxt;
  logic          out_placed_r, out_placed_nxt;

  logic          ram_we    [2];
  logic [AW-1:0] ram_waddr [2];
  cell_t         ram_wdata [2];
  logic [AW-1:0] ram_raddr [2];
  cell_t         ram_rdata [2];

  logic          in_ready;
  logic          in_fire;
  logic          in_range;
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic          cb;
  logic          bb;
  logic [RW-1:0] rb;
  logic          tail;
  logic          proc_en;
  cell_t         cur_in;
  cell_t         bel_in;
  cell_t         key_data;
  move_t         mv;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    fsg_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (ram_we[b]),
      .waddr (ram_waddr[b]),
      .wdata (ram_wdata[b]),
      .raddr (ram_raddr[b]),
      .rdata (ram_rdata[b])
    );
  end

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_bus.ready);
  assign in_fire  = in_bus.valid && in_ready;
  assign in_range = ({1'b0, in_bus.cell_row} < 9'(GRID_ROWS)) &&
                    ({1'b0, in_bus.cell_col} < 9'(GRID_COLS));
  assign in_row   = RW'(in_bus.cell_row);
  assign in_col   = CW'(in_bus.cell_col);

  assign cb       = row_r[0];
  assign bb       = ~row_r[0];
  assign rb       = row_r + RW'(1);
  assign cur_in   = ram_rdata[cb];
  assign bel_in   = ram_rdata[bb];
  assign key_data = ram_rdata[key_row_r[0]];
  assign tail     = (state_r == ST_TAIL1);
  assign proc_en  = (rd_v_r && !rd_first_r) || tail;

  assign mv = settle(curd_r, w0_r, w1_r, tail ? CELL_EMPTY : bel_in, w0v_r, !tail);

  assign in_bus.ready       = in_ready;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.cell_value = out_value_r;
  assign out_bus.placed     = out_placed_r;

  // memory ports
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      ram_we[b]    = 1'b0;
      ram_waddr[b] = '0;
      ram_wdata[b] = CELL_EMPTY;
      ram_raddr[b] = '0;
    end
    case (state_r)
      ST_CLEAR: begin
        for (int b = 0; b < 2; b++) begin
          ram_we[b]    = 1'b1;
          ram_waddr[b] = clr_r;
        end
      end
      ST_IDLE: begin
        ram_raddr[in_row[0]] = baddr(in_row, in_col);
      end
      ST_SPAWN: begin
        if (key_data == CELL_EMPTY) begin
          ram_we[key_row_r[0]]    = 1'b1;
          ram_waddr[key_row_r[0]] = baddr(key_row_r, key_col_r);
          ram_wdata[key_row_r[0]] = color_r;
        end
      end
      ST_SWEEP: begin
        ram_raddr[cb] = baddr(row_r, col_r);
        ram_raddr[bb] = baddr(rb, col_r);
      end
      ST_TAIL2: begin
        ram_we[bb]    = 1'b1;
        ram_waddr[bb] = baddr(rb, pc_r);
        ram_wdata[bb] = w0_r;
      end
      default: begin
      end
    endcase
    if (proc_en) begin
      if (mv.moved) begin
        ram_we[cb]    = 1'b1;
        ram_waddr[cb] = baddr(row_r, pc_r);
        ram_wdata[cb] = CELL_EMPTY;
      end
      if (w0v_r) begin
        ram_we[bb]    = 1'b1;
        ram_waddr[bb] = baddr(rb, pc_r - CW'(1));
        ram_wdata[bb] = mv.nl;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    pc_nxt         = pc_r;
    rd_v_nxt       = 1'b0;
    rd_first_nxt   = 1'b0;
    w0v_nxt        = w0v_r;
    w0_nxt         = w0_r;
    w1_nxt         = w1_r;
    curd_nxt       = curd_r;
    key_row_nxt    = key_row_r;
    key_col_nxt    = key_col_r;
    color_nxt      = color_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_value_nxt  = out_value_r;
    out_placed_nxt = out_placed_r;

    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          key_row_nxt = in_row;
          key_col_nxt = in_col;
          color_nxt   = in_bus.grain_color;
          case (in_bus.operation)
            OP_SPAWN: begin
              if (in_range && in_bus.grain_color != CELL_EMPTY) begin
                state_nxt = ST_SPAWN;
              end else begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = CELL_EMPTY;
                out_placed_nxt = 1'b0;
              end
            end
            OP_TICK: begin
              row_nxt   = RW'(GRID_ROWS - 2);
              col_nxt   = '0;
              state_nxt = ST_SWEEP;
            end
            OP_READ: begin
              if (in_range) begin
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = CELL_EMPTY;
                out_placed_nxt = 1'b0;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = CELL_EMPTY;
              out_placed_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SPAWN: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = CELL_EMPTY;
        out_placed_nxt = (key_data == CELL_EMPTY);
        state_nxt      = ST_IDLE;
      end
      ST_READ: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = key_data;
        out_placed_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      ST_SWEEP: begin
        rd_v_nxt     = 1'b1;
        rd_first_nxt = (col_r == '0);
        col_nxt      = col_r + CW'(1);
        if (col_r == CW'(GRID_COLS - 1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_TAIL1;
      end
      ST_TAIL1: begin
        state_nxt = ST_TAIL2;
      end
      ST_TAIL2: begin
        if (row_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = CELL_EMPTY;
          out_placed_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          row_nxt   = row_r - RW'(1);
          col_nxt   = '0;
          state_nxt = ST_SWEEP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // sliding window over the row below
    if (rd_v_r && rd_first_r) begin
      w1_nxt   = bel_in;
      curd_nxt = cur_in;
      pc_nxt   = '0;
      w0v_nxt  = 1'b0;
    end else if (proc_en) begin
      w0_nxt   = mv.nm;
      w1_nxt   = mv.nr;
      curd_nxt = cur_in;
      w0v_nxt  = 1'b1;
      if (!tail) begin
        pc_nxt = pc_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rd_v_r      <= 1'b0;
      rd_first_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_v_r      <= rd_v_nxt;
      rd_first_r  <= rd_first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    pc_r         <= pc_nxt;
    w0v_r        <= w0v_nxt;
    w0_r         <= w0_nxt;
    w1_r         <= w1_nxt;
    curd_r       <= curd_nxt;
    key_row_r    <= key_row_nxt;
    key_col_r    <= key_col_nxt;
    color_r      <= color_nxt;
    out_value_r  <= out_value_nxt;
    out_placed_r <= out_placed_nxt;
  end

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !out_valid_r)
    else $error("result pending while an item is in progress");

  a_left_valid: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en |-> (w0v_r == (pc_r != '0)))
    else $error("down-left window entry out of step with column");

  a_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == ST_SWEEP || state_r == ST_LAST))
    else $error("sweep read data outside a sweep");

  a_tail_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LAST |=> state_r == ST_TAIL1 ##1 state_r == ST_TAIL2)
    else $error("row tail sequence broken");

endmodule

// ----- design/fsg_ram.sv -----
module fsg_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
